[rtl/assert_macros.svh]
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked while out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dss_pkg.sv]
`default_nettype none
package dss_pkg;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned MinPerHour = 60;
  localparam int unsigned HourPerDay = 6;
  localparam int unsigned DayPerYear = 426;

  localparam logic [7:0] SEG_SEC   = 8'h22;
  localparam logic [7:0] SEG_MIN   = 8'h02;
  localparam logic [7:0] SEG_HOUR  = 8'h17;
  localparam logic [7:0] SEG_DAY   = 8'h3D;
  localparam logic [7:0] SEG_YEAR  = 8'h27;
  localparam logic [7:0] SEG_MINUS = 8'h01;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  // Broken-down duration
  typedef struct packed {
    logic       neg;
    logic [9:0] y;
    logic [8:0] d;
    logic [2:0] h;
    logic [5:0] m;
    logic [5:0] s;
  } dur_t;

  // One display character: mark flag plus byte
  typedef struct packed {
    logic       mark;
    logic [7:0] val;
  } chr_t;

  typedef struct packed {
    chr_t [7:0] ch;
    logic [3:0] n;
  } line_t;

  // Split a value 0-99 into tens and units
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [3:0] t;
    t = 4'((15'(v) * 15'd205) >> 11);
    return {t, 4'(v - 7'(t) * 7'd10)};
  endfunction
endpackage
`default_nettype wire

[rtl/dss_split.sv]
`default_nettype none
// Four-stage split of magnitude into s, m, h, d, y by reciprocal multiply
module dss_split (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic [31:0]        seconds,
  output logic                    out_v,
  output dss_pkg::dur_t           dur
);
  logic        v1_r, v2_r, v3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [31:0] mag1_r;
  logic [5:0]  s2_r, s3_r;
  logic [25:0] q2_r;
  logic [8:0]  rb3_r;
  logic [19:0] q3_r;
  logic [31:0] mag_nxt;
  logic [63:0] p60a;
  logic [25:0] qa;
  logic [31:0] ra;
  logic [51:0] p360;
  logic [19:0] qb;
  logic [25:0] rb;
  logic [45:0] p426;
  logic [9:0]  qc;
  logic [19:0] rc;
  logic [18:0] p60b;
  logic [2:0]  hq;
  logic [5:0]  mr;

  assign mag_nxt = seconds[31] ? 32'(~seconds + 32'd1) : seconds;

  // Stage 2: divide by 60 (floor(x*0x88888889 >> 37))
  assign p60a = 64'(mag1_r) * 64'h0000_0000_8888_8889;
  assign qa   = 26'(p60a >> 37);
  assign ra   = mag1_r - 32'(qa) * 32'(dss_pkg::SecPerMin);

  // Stage 3: divide q by 360 = 60*6, keep the remainder
  assign p360 = 52'(q2_r) * 52'd47721859;  // ceil(2^34/360)
  assign qb   = 20'(p360 >> 34);
  assign rb   = q2_r - 26'(qb) * 26'd360;

  // Stage 4: divide by 426
  assign p426 = 46'(q3_r) * 46'd1260261; // ceil(2^29/426)
  assign qc   = 10'(p426 >> 29);
  assign rc   = q3_r - 20'(qc) * 20'(dss_pkg::DayPerYear);

  // Stage 4: split the 0-359 remainder into hours and minutes
  assign p60b = 19'(rb3_r) * 19'd547;    // ceil(2^15/60)
  assign hq   = 3'(p60b >> 15);
  assign mr   = 6'(rb3_r - 9'(hq) * 9'd60);

  // Advance pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; out_v <= 1'b0;
    end else if (en) begin
      v1_r <= in_v; v2_r <= v1_r; v3_r <= v2_r; out_v <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= mag_nxt; neg1_r <= seconds[31];
      q2_r <= qa; s2_r <= 6'(ra); neg2_r <= neg1_r;
      q3_r <= qb; s3_r <= s2_r; neg3_r <= neg2_r;
      rb3_r <= 9'(rb);
      dur.neg <= neg3_r; dur.s <= s3_r; dur.m <= mr; dur.h <= hq;
      dur.d <= 9'(rc); dur.y <= qc;
    end
  end
endmodule
`default_nettype wire

[rtl/dss_build.sv]
`default_nettype none
// Three stages: split decimal digits, build character line, then pad and map
module dss_build (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire dss_pkg::dur_t dur,
  output logic               out_v,
  output logic [63:0]        digits,
  output logic [7:0]         mask
);
  dss_pkg::line_t ln, ln_r;
  dss_pkg::dur_t  dur_r;
  logic           v0_r, v_r;
  logic [7:0]     dd, hm, hs, yd;
  logic [3:0]     yh, dh;
  logic [7:0]     dd_r, hm_r, hs_r, yd_r;
  logic [3:0]     yh_r, dh_r;

  // Hundreds digit of a value up to 425
  function automatic logic [3:0] div100(input logic [9:0] v);
    return 4'((16'(v) * 16'd41) >> 12);
  endfunction

  // Year, day, minute and second digits
  always_comb begin
    yh = div100(dur.y);
    dh = div100(10'(dur.d));
    yd = dss_pkg::bcd2(7'(dur.y - 10'(yh) * 10'd100));
    dd = dss_pkg::bcd2(7'(dur.d - 9'(dh) * 9'd100));
    hm = dss_pkg::bcd2(7'(dur.m));
    hs = dss_pkg::bcd2(7'(dur.s));
  end

  // Hold digits for the layout stage
  always_ff @(posedge clk) begin
    if (en) begin
      dur_r <= dur;
      yh_r  <= yh; yd_r <= yd;
      dh_r  <= dh; dd_r <= dd;
      hm_r  <= hm; hs_r <= hs;
    end
  end

  // Lay out characters left to right
  always_comb begin
    logic ny, nd, nh, nm, stop;
    ln = '0;
    stop = 1'b0;
    ny = (dur_r.y == '0);
    if (dur_r.neg) begin
      ln.ch[ln.n[2:0]] = '{1'b1, dss_pkg::SEG_MINUS}; ln.n++;
    end
    if (!ny) begin
      if (yh_r != '0) begin ln.ch[ln.n[2:0]] = '{1'b0, 8'(yh_r)}; ln.n++; end
      if (yh_r != '0 || yd_r[7:4] != '0) begin
        ln.ch[ln.n[2:0]] = '{1'b0, 8'(yd_r[7:4])}; ln.n++;
      end
      ln.ch[ln.n[2:0]] = '{1'b0, 8'(yd_r[3:0])}; ln.n++;
      ln.ch[ln.n[2:0]] = '{1'b1, dss_pkg::SEG_YEAR}; ln.n++;
    end
    nd = (dur_r.d == '0) && ny;
    if (ln.n >= 4'd6) stop = 1'b1;
    if (!stop) begin
      if (!ny || dh_r != '0) begin ln.ch[ln.n[2:0]] = '{1'b0, 8'(dh_r)}; ln.n++; end
      if (!ny || dur_r.d >= 9'd10) begin
        ln.ch[ln.n[2:0]] = '{1'b0, 8'(dd_r[7:4])}; ln.n++;
      end
      if (!nd) begin
        ln.ch[ln.n[2:0]] = '{1'b0, 8'(dd_r[3:0])}; ln.n++;
        if (ln.n == 4'd8) stop = 1'b1;
        else begin
          ln.ch[ln.n[2:0]] = '{1'b1, dss_pkg::SEG_DAY}; ln.n++;
          if (ln.n == 4'd8) stop = 1'b1;
        end
      end
    end
    nh = (dur_r.h == '0) && nd;
    if (!stop && !nh) begin
      ln.ch[ln.n[2:0]] = '{1'b0, 8'(dur_r.h)}; ln.n++;
      if (ln.n == 4'd8) stop = 1'b1;
      else begin
        ln.ch[ln.n[2:0]] = '{1'b1, dss_pkg::SEG_HOUR}; ln.n++;
        if (ln.n == 4'd8) stop = 1'b1;
      end
    end
    nm = (dur_r.m == '0) && nh;
    if (!stop && ln.n >= 4'd7) stop = 1'b1;
    if (!stop) begin
      if (!nh || hm_r[7:4] != '0) begin
        ln.ch[ln.n[2:0]] = '{1'b0, 8'(hm_r[7:4])}; ln.n++;
      end
      if (!nm) begin
        ln.ch[ln.n[2:0]] = '{1'b0, 8'(hm_r[3:0])}; ln.n++;
        if (ln.n == 4'd8) stop = 1'b1;
        else begin
          ln.ch[ln.n[2:0]] = '{1'b1, dss_pkg::SEG_MIN}; ln.n++;
          if (ln.n == 4'd8) stop = 1'b1;
        end
      end
    end
    if (!stop && ln.n >= 4'd7) stop = 1'b1;
    if (!stop) begin
      if (!nm || hs_r[7:4] != '0) begin
        ln.ch[ln.n[2:0]] = '{1'b0, 8'(hs_r[7:4])}; ln.n++;
      end
      ln.ch[ln.n[2:0]] = '{1'b0, 8'(hs_r[3:0])}; ln.n++;
      if (ln.n != 4'd8) begin ln.ch[ln.n[2:0]] = '{1'b1, dss_pkg::SEG_SEC}; ln.n++; end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v_r <= 1'b0; out_v <= 1'b0;
    end else if (en) begin
      v0_r <= in_v; v_r <= v0_r; out_v <= v_r;
    end
  end

  // Right-align: character k from the right is ch[n-1-k]
  always_ff @(posedge clk) begin
    if (en) begin
      ln_r <= ln;
      for (int k = 0; k < 8; k++) begin
        if (4'(k) < ln_r.n) begin
          digits[8*k +: 8] <= ln_r.ch[3'(ln_r.n - 4'd1 - 4'(k))].val;
          mask[k] <= !ln_r.ch[3'(ln_r.n - 4'd1 - 4'(k))].mark;
        end else begin
          digits[8*k +: 8] <= dss_pkg::SEG_BLANK;
          mask[k] <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/duration_to_seven_segment_core.sv]
`default_nettype none
// Channel | Dir | Payload
// in_     | in  | tdata[31:0] seconds (signed)
// out_    | out | tdata[71:0] digit_0..digit_7, decode_mask
// One word per cycle while the output is not stalled, through the divider and layout stages.
// The pipeline advances whenever the output register is empty or being taken.
// Synchronous active-low reset clears valid bits only.
module duration_to_seven_segment_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seconds
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // digit_0 .. digit_7, decode_mask
);
  logic          en, sv, bv;
  dss_pkg::dur_t dur;
  logic [63:0]   dg;
  logic [7:0]    mk;

  // Stall whole pipe while output is held
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  dss_split u_split (.clk, .rst_n, .en, .in_v(in_tvalid), .seconds(in_tdata),
    .out_v(sv), .dur);
  dss_build u_build (.clk, .rst_n, .en, .in_v(sv), .dur, .out_v(bv),
    .digits(dg), .mask(mk));

  assign out_tvalid = bv;
  assign out_tdata  = {mk, dg};

`include "assert_macros.svh"
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "stall")
  `ASSERT_IMPL(a_rdy, clk, rst_n, !out_tvalid, in_tready, "ready")
  `ASSERT_IMPL(a_mask, clk, rst_n, out_tvalid, !out_tdata[64] || out_tdata[7:0] <= 8'd9, "digit0 not 0-9")
endmodule
`default_nettype wire
